// File: rtl/erlb_pkg.sv
// shared types and constants for the event rate limiter with ban
package erlb_pkg;

    localparam int NOW_W   = 44;
    localparam int DDL_W   = 45;
    localparam int SEC_W   = 35;
    localparam int WIN_W   = 22;
    localparam int PROD_W  = 33;
    localparam int OPROD_W = 55;
    localparam int CNT_W   = 11;
    localparam int OVR_W   = 8;
    localparam int AE_W    = 10;
    localparam int WS_W    = 12;
    localparam int BS_W    = 17;

    localparam int DIV_W     = 48;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int DVS_W     = 10;

    localparam logic [DVS_W-1:0] MS_PER_SEC = 10'd1000;
    localparam logic [OVR_W-1:0] OVR_LIMIT  = 8'd3;
    localparam logic [OVR_W-1:0] OVR_MAX    = 8'd255;
    localparam logic [CNT_W-1:0] CNT_MAX    = 11'd2047;

    localparam logic [1:0] REG_ALLOWED = 2'd0;
    localparam logic [1:0] REG_WINDOW  = 2'd1;
    localparam logic [1:0] REG_BAN     = 2'd2;

    typedef enum logic [1:0] {
        DIV_NOW  = 2'd0,
        DIV_PROD = 2'd1,
        DIV_DDL  = 2'd2
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     prep;
        logic     div_start;
        t_div_sel div_sel;
        logic     sec_cap;
        logic     deadline;
        logic     eval;
        logic     ovr_mul;
        logic     roll;
        logic     ban_final;
        logic     push;
    } t_dp_cmd;

    typedef struct packed {
        logic bypass;
        logic new_win;
        logic fast;
        logic div_busy;
        logic out_busy;
    } t_dp_sts;

endpackage

// File: rtl/erlb_div.sv
// iterative restoring divider, four quotient bits per cycle
module erlb_div import erlb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int CW = $clog2(DIV_STEPS + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_acc;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DIV_W-1:0] n_acc;
    logic [DVS_W-1:0] n_rem;
    logic [DVS_W:0]   v_t;

    always_comb begin
        n_acc = r_acc;
        n_rem = r_rem;
        v_t   = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            v_t   = {n_rem, n_acc[DIV_W-1]};
            n_acc = {n_acc[DIV_W-2:0], 1'b0};
            if (v_t >= {1'b0, r_dvs}) begin
                v_t      = v_t - {1'b0, r_dvs};
                n_acc[0] = 1'b1;
            end
            n_rem = v_t[DVS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CW'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_acc;

endmodule

// File: rtl/erlb_dp.sv
// datapath: limiter state, arithmetic steps and output register
module erlb_dp import erlb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [AE_W-1:0] i_allowed,
    input  logic [WS_W-1:0] i_window_sec,
    input  logic [BS_W-1:0] i_ban_sec,
    input  logic [NOW_W-1:0] i_now_ms,
    input  logic            i_exempt,
    input  t_dp_cmd         i_cmd,
    output t_dp_sts         o_sts,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic            o_too_soon,
    output logic            o_clear_warning_flag
);

    logic [NOW_W-1:0]   r_now;
    logic               r_exempt;
    logic [WIN_W-1:0]   r_win_ms;
    logic [SEC_W-1:0]   r_now_sec;
    logic [PROD_W-1:0]  r_prod;
    logic [DDL_W-1:0]   r_deadline;
    logic [DDL_W-1:0]   r_diff;
    logic               r_near;
    logic [OPROD_W-1:0] r_ovr_prod;
    logic               r_res_too_soon;
    logic               r_res_clear;
    logic               r_banned;

    logic [NOW_W-1:0]   r_win_start;
    logic [SEC_W-1:0]   r_ban_until;
    logic [CNT_W-1:0]   r_event_count;
    logic [OVR_W-1:0]   r_overage;

    logic               r_out_valid;
    logic               r_out_too_soon;
    logic               r_out_clear;

    logic [DIV_W-1:0]   div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic               div_busy;
    logic [DIV_W-1:0]   div_q;

    logic [WS_W-1:0]    win_sec;
    logic               full;
    logic               ovr_hit;
    logic [CNT_W-1:0]   cnt_sub;
    logic [CNT_W-1:0]   cnt_next;
    logic [OVR_W-1:0]   ovr_next;
    logic [DDL_W-1:0]   now_ext;
    logic [DDL_W-2+1:0] near_lim;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_NOW: begin
                div_dividend = {{(DIV_W-NOW_W){1'b0}}, r_now};
                div_divisor  = MS_PER_SEC;
            end
            DIV_PROD: begin
                div_dividend = {{(DIV_W-PROD_W){1'b0}}, r_prod};
                div_divisor  = i_allowed;
            end
            DIV_DDL: begin
                div_dividend = {{(DIV_W-DDL_W){1'b0}}, r_deadline};
                div_divisor  = MS_PER_SEC;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = MS_PER_SEC;
            end
        endcase
    end

    erlb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign win_sec  = (i_window_sec == '0) ? WS_W'(1) : i_window_sec;
    assign now_ext  = {1'b0, r_now};
    assign near_lim = now_ext + DDL_W'(r_win_ms);
    assign full     = r_event_count >= {1'b0, i_allowed};
    assign ovr_hit  = r_ovr_prod >= OPROD_W'({r_win_ms, 2'b00});
    assign cnt_sub  = full ? (r_event_count - {1'b0, i_allowed}) : r_event_count;
    assign cnt_next = (cnt_sub < CNT_MAX) ? (cnt_sub + 1'b1) : cnt_sub;
    assign ovr_next = (full && ovr_hit && r_overage < OVR_MAX) ? (r_overage + 1'b1)
                                                                : r_overage;

    assign o_sts.bypass   = (i_allowed == '0) || r_exempt;
    assign o_sts.new_win  = (r_win_start == '0) || (r_deadline <= now_ext);
    assign o_sts.fast     = r_near && (ovr_next < OVR_LIMIT);
    assign o_sts.div_busy = div_busy;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now    <= i_now_ms;
            r_exempt <= i_exempt;
        end
        if (i_cmd.prep) begin
            r_win_ms       <= WIN_W'(win_sec) * WIN_W'(MS_PER_SEC);
            r_res_too_soon <= 1'b0;
            r_res_clear    <= 1'b0;
            r_banned       <= 1'b0;
        end
        if (i_cmd.sec_cap) begin
            r_now_sec <= div_q[SEC_W-1:0];
            r_prod    <= PROD_W'(r_event_count) * PROD_W'(r_win_ms);
            if (r_ban_until != '0 && div_q[SEC_W-1:0] < r_ban_until) begin
                r_banned <= 1'b1;
            end
        end
        if (i_cmd.deadline) begin
            r_deadline <= {1'b0, r_win_start} + DDL_W'(div_q[PROD_W-1:0]);
        end
        if (i_cmd.eval) begin
            r_diff <= r_deadline - now_ext;
            r_near <= r_deadline < near_lim;
            if (o_sts.new_win) begin
                r_res_too_soon <= r_banned;
                r_res_clear    <= !r_banned;
            end
        end
        if (i_cmd.ovr_mul) begin
            r_ovr_prod <= OPROD_W'(r_diff) * OPROD_W'(i_allowed);
        end
        if (i_cmd.roll && o_sts.fast) begin
            r_res_too_soon <= r_banned;
        end
        if (i_cmd.ban_final) begin
            r_res_too_soon <= 1'b1;
        end
    end

    // limiter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start   <= '0;
            r_ban_until   <= '0;
            r_event_count <= '0;
            r_overage     <= '0;
        end else begin
            if (i_cmd.sec_cap && r_ban_until != '0 && div_q[SEC_W-1:0] >= r_ban_until) begin
                r_ban_until <= '0;
            end
            if (i_cmd.eval && o_sts.new_win) begin
                r_win_start   <= r_now;
                r_event_count <= CNT_W'(1);
                r_overage     <= '0;
            end
            if (i_cmd.roll) begin
                r_event_count <= cnt_next;
                r_overage     <= ovr_next;
                if (full) begin
                    r_win_start <= r_win_start + NOW_W'(r_win_ms);
                end
                if (!o_sts.fast && r_ban_until == '0 && i_ban_sec != '0) begin
                    r_ban_until <= r_now_sec + SEC_W'(i_ban_sec);
                end
            end
            if (i_cmd.ban_final) begin
                if (r_ban_until == '0 || {1'b0, r_ban_until} < div_q[SEC_W:0]) begin
                    r_ban_until <= div_q[SEC_W-1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_too_soon <= r_res_too_soon;
            r_out_clear    <= r_res_clear;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_too_soon           = r_out_too_soon;
    assign o_clear_warning_flag = r_out_clear;

endmodule

// File: rtl/erlb_ctrl.sv
// controller state machine sequencing the datapath steps
module erlb_ctrl import erlb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_PREP = 10'b0000000010,
        S_SEC  = 10'b0000000100,
        S_QST  = 10'b0000001000,
        S_QDL  = 10'b0000010000,
        S_EVAL = 10'b0000100000,
        S_OVR  = 10'b0001000000,
        S_ROLL = 10'b0010000000,
        S_BAN  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.bypass) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_NOW;
                    n_state         = S_SEC;
                end
            end
            S_SEC: begin
                if (!i_sts.div_busy) begin
                    o_cmd.sec_cap = 1'b1;
                    n_state       = S_QST;
                end
            end
            S_QST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_PROD;
                n_state         = S_QDL;
            end
            S_QDL: begin
                if (!i_sts.div_busy) begin
                    o_cmd.deadline = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.new_win ? S_DONE : S_OVR;
            end
            S_OVR: begin
                o_cmd.ovr_mul = 1'b1;
                n_state       = S_ROLL;
            end
            S_ROLL: begin
                o_cmd.roll = 1'b1;
                if (i_sts.fast) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_DDL;
                    n_state         = S_BAN;
                end
            end
            S_BAN: begin
                if (!i_sts.div_busy) begin
                    o_cmd.ban_final = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/event_rate_limiter_with_ban.sv
// top level of the event rate limiter with ban: config registers and core
//
//  channel  direction  handshake               payload
//  in       sink       i_in_valid/o_in_ready    i_now_ms, i_exempt
//  out      source     o_out_valid/i_out_ready  o_too_soon, o_clear_warning_flag
//  apb      slave      psel/penable/pready      paddr, pwdata, prdata
//
// an exempt or unlimited transaction bypasses the divider, one that opens a window runs two divisions,
// one that reaches the ban path runs three
// all divisions go through the single shared divider
// reset is synchronous and active low; it clears the window, counts and ban time
// the next transaction is accepted while a result waits in the output register
// a stalled output holds the finished result until it is taken
module event_rate_limiter_with_ban import erlb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [NOW_W-1:0] i_now_ms,
    input  logic             i_exempt,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_too_soon,
    output logic             o_clear_warning_flag
);

    logic [AE_W-1:0] r_allowed;
    logic [WS_W-1:0] r_window_sec;
    logic [BS_W-1:0] r_ban_sec;
    logic            cfg_wr;
    t_dp_cmd         cmd;
    t_dp_sts         sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allowed    <= '0;
            r_window_sec <= WS_W'(1);
            r_ban_sec    <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ALLOWED: r_allowed    <= pwdata[AE_W-1:0];
                REG_WINDOW:  r_window_sec <= pwdata[WS_W-1:0];
                REG_BAN:     r_ban_sec    <= pwdata[BS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ALLOWED: prdata = 32'(r_allowed);
            REG_WINDOW:  prdata = 32'(r_window_sec);
            REG_BAN:     prdata = 32'(r_ban_sec);
            default:     prdata = '0;
        endcase
    end

    erlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    erlb_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_allowed            (r_allowed),
        .i_window_sec         (r_window_sec),
        .i_ban_sec            (r_ban_sec),
        .i_now_ms             (i_now_ms),
        .i_exempt             (i_exempt),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_too_soon           (o_too_soon),
        .o_clear_warning_flag (o_clear_warning_flag)
    );

endmodule
